/* hdl/khvf_pkg.sv */
// Shared types, constants and saturating helpers of the height and velocity Kalman filter.
`timescale 1ns / 1ps

package khvf_pkg;

  typedef logic signed [63:0] q48_t;
  typedef logic signed [31:0] q16_t;

  localparam q48_t SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q48_t ONE_Q48 = 64'sh0001_0000_0000_0000;
  localparam logic [62:0] MASK63 = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMIN65 = -65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam q48_t I32_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam q48_t I32_MIN64 = -64'sh0000_0000_8000_0000;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_TIME_STEP = 3'd0;
  localparam logic [2:0] CFG_NOISE_PP  = 3'd1;
  localparam logic [2:0] CFG_NOISE_PV  = 3'd2;
  localparam logic [2:0] CFG_NOISE_VV  = 3'd3;
  localparam logic [2:0] CFG_MEAS_NOISE = 3'd4;

  // Reset values of the registers.
  localparam logic [31:0] RST_TIME_STEP = 32'd17179869;
  localparam logic [62:0] RST_NOISE_PP  = 63'd36029;
  localparam logic [62:0] RST_NOISE_PV  = 63'd9007199;
  localparam logic [62:0] RST_NOISE_VV  = 63'd4503599627;
  localparam logic [62:0] RST_MEAS_NOISE = 63'd2251799813685;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M_VDT, ST_A_PS1, ST_M_VVDT, ST_A_P12A, ST_A_P12B, ST_A_P21A, ST_A_S,
    ST_M_SDT, ST_A_P11A, ST_A_P11B, ST_A_P21B, ST_A_P22, ST_A_INN, ST_A_IC,
    ST_D_K1, ST_D_K2, ST_M_HUP, ST_A_H, ST_M_VUP, ST_A_V, ST_A_KEEP,
    ST_M_CHH, ST_M_CHV, ST_M_N1, ST_A_CVH, ST_M_N2, ST_A_CVV, ST_OUT
  } state_t;

  function automatic logic [63:0] mag64(input q48_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  // Clamp an exact 65-bit sum to plus or minus (2^63 - 1).
  function automatic q48_t sat64(input logic signed [64:0] s);
    if (s > SMAX65) return SMAX;
    else if (s < SMIN65) return -SMAX;
    else return s[63:0];
  endfunction

  function automatic q16_t sat32(input q48_t x);
    if (x > I32_MAX64) return 32'sh7FFF_FFFF;
    else if (x < I32_MIN64) return -32'sh8000_0000;
    else return x[31:0];
  endfunction

endpackage

/* hdl/khvf_mul.sv */
// Iterative fixed-point multiplier: four 32x32 partial products, rounding and saturation.
`timescale 1ns / 1ps

module khvf_mul import khvf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  q48_t a,
  input  q48_t b,
  input  logic sh48,
  output logic busy,
  output logic done,
  output q48_t result
);

  logic [63:0]  am_r, bm_r;
  logic         neg_r, sh48_r, run_r, done_r;
  logic [127:0] acc_r;
  logic [2:0]   step_r;
  q48_t         result_r;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rnd;
  logic         over;
  logic [63:0]  r;
  logic [62:0]  m63;

  always_comb begin
    a_half = step_r[1] ? am_r[63:32] : am_r[31:0];
    b_half = step_r[0] ? bm_r[63:32] : bm_r[31:0];
    pp = a_half * b_half;
    case (step_r[1:0]) inside
      2'd0:       pp_sh = {64'd0, pp};
      2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
      default:    pp_sh = {pp, 64'd0};
    endcase
    // Round half away from zero on the magnitude, then drop the fraction bits.
    rnd = acc_r + (sh48_r ? (128'd1 << 47) : (128'd1 << 31));
    over = sh48_r ? (|rnd[127:112]) : (|rnd[127:96]);
    r = sh48_r ? rnd[111:48] : rnd[95:32];
    m63 = (over || r[63]) ? MASK63 : r[62:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (!run_r) begin
        if (start) begin
          am_r   <= mag64(a);
          bm_r   <= mag64(b);
          neg_r  <= a[63] ^ b[63];
          sh48_r <= sh48;
          acc_r  <= 128'd0;
          step_r <= 3'd0;
          run_r  <= 1'b1;
        end
      end else if (step_r == 3'd4) begin
        result_r <= neg_r ? -q48_t'({1'b0, m63}) : q48_t'({1'b0, m63});
        done_r   <= 1'b1;
        run_r    <= 1'b0;
      end else begin
        acc_r  <= acc_r + pp_sh;
        step_r <= step_r + 3'd1;
      end
    end
  end

  assign busy   = run_r;
  assign done   = done_r;
  assign result = result_r;

endmodule

/* hdl/khvf_div.sv */
// Serial restoring divider: (num << 48) / den, one quotient bit per cycle, saturated.
`timescale 1ns / 1ps

module khvf_div import khvf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  q48_t        num,
  input  logic [62:0] den,
  output logic        busy,
  output logic        done,
  output q48_t        result
);

  // The dividend |num| << 48 has no bits above bit 110.
  localparam logic [6:0] TOP_BIT = 7'd110;

  logic [62:0]  d_r, rem_r, q_r;
  logic [110:0] dvd_r;
  logic [6:0]   idx_r;
  logic         over_r, neg_r, run_r, done_r;
  q48_t         result_r;

  logic [63:0]  rs;
  logic         ge;
  logic [62:0]  rem_nxt, q_fin, mag;
  logic [63:0]  num_mag;

  always_comb begin
    num_mag = mag64(num);
    rs      = {rem_r, dvd_r[110]};
    ge      = rs >= {1'b0, d_r};
    rem_nxt = ge ? 63'(rs - {1'b0, d_r}) : rs[62:0];
    q_fin   = {q_r[61:0], ge};
    mag     = over_r ? MASK63 : q_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= TOP_BIT;
    end else begin
      done_r <= 1'b0;
      if (!run_r) begin
        if (start) begin
          d_r    <= den;
          rem_r  <= 63'd0;
          q_r    <= 63'd0;
          dvd_r  <= {num_mag[62:0], 48'd0};
          neg_r  <= num[63];
          over_r <= 1'b0;
          idx_r  <= TOP_BIT;
          run_r  <= 1'b1;
        end
      end else begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[109:0], 1'b0};
        if (idx_r >= 7'd63) begin
          over_r <= over_r | ge;
        end else begin
          q_r <= q_fin;
        end
        if (idx_r == 7'd0) begin
          result_r <= neg_r ? -q48_t'({1'b0, mag}) : q48_t'({1'b0, mag});
          done_r   <= 1'b1;
          run_r    <= 1'b0;
        end else begin
          idx_r <= idx_r - 7'd1;
        end
      end
    end
  end

  assign busy   = run_r;
  assign done   = done_r;
  assign result = result_r;

endmodule

/* hdl/kalman_height_velocity_filter.sv */
// Top level of the two-state height and velocity Kalman filter with its sequencer.
`timescale 1ns / 1ps

// Each input beat carries one barometric height sample (signed Q16.16); the filter
// predicts height and vertical velocity forward by time_step, propagates the 2x2
// covariance with the process noise, computes the two gains and updates state and
// covariance, then emits one output beat with height, velocity and height variance.
// All work runs through one small sequencer that drives a shared 65-bit saturating
// adder, an iterative multiplier (four 32x32 partial products) and a serial
// restoring divider (111 steps per gain). The two divisions dominate an update
// when the innovation variance is positive; otherwise no division is run. The
// input is ready only while the sequencer is idle; a finished result sits in an
// output register, so the next sample can be taken while the previous result
// waits. Configuration writes are always accepted and should only be issued
// while no update is in flight.
module kalman_height_velocity_filter import khvf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] measured_height
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] height_estimate, [63:32] velocity_estimate,
                                   // [126:64] height_variance, [127] zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [31:0] time_step_r;
  logic [62:0] noise_pp_r, noise_pv_r, noise_vv_r, meas_noise_r;

  // Filter state.
  q16_t height_r, velocity_r;
  q48_t cov_hh_r, cov_hv_r, cov_vh_r, cov_vv_r;

  // Working registers of one update.
  q16_t meas_r, ps1_r;
  q48_t tmp_r, t_r, p11_r, p12_r, p21_r, p22_r, inn_r, ic_r, k1_r, k2_r, keep_r;
  logic op_started_r;

  // Output register.
  logic        out_valid_r;
  q16_t        out_h_r, out_v_r;
  logic [62:0] out_var_r;

  // Shared adder.
  q48_t alu_a, alu_b, alu_sat;
  logic alu_sub;
  logic signed [64:0] alu_sum;
  q16_t alu_w32;

  // Multiplier and divider hookup.
  q48_t mul_a, mul_b, mul_res, div_num, div_res;
  logic mul_sh48, mul_start, mul_busy, mul_done;
  logic div_start, div_busy, div_done;
  logic step_done, ic_pos, in_acc;
  q48_t dt64, h64, v64, ps1_64, meas64;

  assign dt64   = {32'd0, time_step_r};
  assign h64    = {{32{height_r[31]}}, height_r};
  assign v64    = {{32{velocity_r[31]}}, velocity_r};
  assign ps1_64 = {{32{ps1_r[31]}}, ps1_r};
  assign meas64 = {{32{meas_r[31]}}, meas_r};
  assign ic_pos = !ic_r[63] && (ic_r != 64'sd0);
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    alu_sum = alu_sub ? ({alu_a[63], alu_a} - {alu_b[63], alu_b})
                      : ({alu_a[63], alu_a} + {alu_b[63], alu_b});
    alu_sat = sat64(alu_sum);
    // State sums wrap in 64 bits before the 32-bit clamp.
    alu_w32 = sat32(alu_sum[63:0]);
  end

  khvf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .sh48   (mul_sh48),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  khvf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (ic_r[62:0]),
    .busy   (div_busy),
    .done   (div_done),
    .result (div_res)
  );

  // Operand selection and unit control for each step.
  always_comb begin
    alu_a = 64'sd0;
    alu_b = 64'sd0;
    alu_sub = 1'b0;
    mul_a = 64'sd0;
    mul_b = 64'sd0;
    mul_sh48 = 1'b0;
    mul_start = 1'b0;
    div_num = 64'sd0;
    div_start = 1'b0;
    step_done = 1'b1;
    unique case (state_r)
      ST_IDLE:   step_done = in_acc;
      ST_M_VDT:  begin mul_a = v64;      mul_b = dt64; end
      ST_A_PS1:  begin alu_a = h64;      alu_b = tmp_r; end
      ST_M_VVDT: begin mul_a = cov_vv_r; mul_b = dt64; end
      ST_A_P12A: begin alu_a = cov_hv_r; alu_b = t_r; end
      ST_A_P12B: begin alu_a = p12_r;    alu_b = {1'b0, noise_pv_r}; end
      ST_A_P21A: begin alu_a = cov_vh_r; alu_b = t_r; end
      ST_A_S:    begin alu_a = cov_hv_r; alu_b = p21_r; end
      ST_M_SDT:  begin mul_a = tmp_r;    mul_b = dt64; end
      ST_A_P11A: begin alu_a = cov_hh_r; alu_b = tmp_r; end
      ST_A_P11B: begin alu_a = p11_r;    alu_b = {1'b0, noise_pp_r}; end
      ST_A_P21B: begin alu_a = p21_r;    alu_b = {1'b0, noise_pv_r}; end
      ST_A_P22:  begin alu_a = cov_vv_r; alu_b = {1'b0, noise_vv_r}; end
      ST_A_INN:  begin alu_a = meas64;   alu_b = ps1_64; alu_sub = 1'b1; end
      ST_A_IC:   begin alu_a = p11_r;    alu_b = {1'b0, meas_noise_r}; end
      ST_D_K1:   div_num = p11_r;
      ST_D_K2:   div_num = p21_r;
      ST_M_HUP:  begin mul_a = k1_r;     mul_b = inn_r; mul_sh48 = 1'b1; end
      ST_A_H:    begin alu_a = ps1_64;   alu_b = tmp_r; end
      ST_M_VUP:  begin mul_a = k2_r;     mul_b = inn_r; mul_sh48 = 1'b1; end
      ST_A_V:    begin alu_a = v64;      alu_b = tmp_r; end
      ST_A_KEEP: begin alu_a = ONE_Q48;  alu_b = k1_r; alu_sub = 1'b1; end
      ST_M_CHH:  begin mul_a = p11_r;    mul_b = keep_r; mul_sh48 = 1'b1; end
      ST_M_CHV:  begin mul_a = p12_r;    mul_b = keep_r; mul_sh48 = 1'b1; end
      ST_M_N1:   begin mul_a = p11_r;    mul_b = k2_r; mul_sh48 = 1'b1; end
      ST_A_CVH:  begin alu_a = p21_r;    alu_b = tmp_r; alu_sub = 1'b1; end
      ST_M_N2:   begin mul_a = p12_r;    mul_b = k2_r; mul_sh48 = 1'b1; end
      ST_A_CVV:  begin alu_a = p22_r;    alu_b = tmp_r; alu_sub = 1'b1; end
      ST_OUT:    step_done = !out_valid_r || out_tready;
      default:   step_done = 1'b1;
    endcase
    // Multiply steps start the unit once and finish when it reports done.
    if (state_r == ST_M_VDT || state_r == ST_M_VVDT || state_r == ST_M_SDT ||
        state_r == ST_M_HUP || state_r == ST_M_VUP || state_r == ST_M_CHH ||
        state_r == ST_M_CHV || state_r == ST_M_N1 || state_r == ST_M_N2) begin
      mul_start = !op_started_r;
      step_done = mul_done;
    end
    // With a nonpositive innovation variance both gains are zero, no division.
    if ((state_r == ST_D_K1 || state_r == ST_D_K2) && ic_pos) begin
      div_start = !op_started_r;
      step_done = div_done;
    end
  end

  // Next state: a fixed chain of steps.
  always_comb begin
    state_nxt = state_r;
    if (step_done) begin
      unique case (state_r)
        ST_IDLE:   state_nxt = ST_M_VDT;
        ST_M_VDT:  state_nxt = ST_A_PS1;
        ST_A_PS1:  state_nxt = ST_M_VVDT;
        ST_M_VVDT: state_nxt = ST_A_P12A;
        ST_A_P12A: state_nxt = ST_A_P12B;
        ST_A_P12B: state_nxt = ST_A_P21A;
        ST_A_P21A: state_nxt = ST_A_S;
        ST_A_S:    state_nxt = ST_M_SDT;
        ST_M_SDT:  state_nxt = ST_A_P11A;
        ST_A_P11A: state_nxt = ST_A_P11B;
        ST_A_P11B: state_nxt = ST_A_P21B;
        ST_A_P21B: state_nxt = ST_A_P22;
        ST_A_P22:  state_nxt = ST_A_INN;
        ST_A_INN:  state_nxt = ST_A_IC;
        ST_A_IC:   state_nxt = ST_D_K1;
        ST_D_K1:   state_nxt = ST_D_K2;
        ST_D_K2:   state_nxt = ST_M_HUP;
        ST_M_HUP:  state_nxt = ST_A_H;
        ST_A_H:    state_nxt = ST_M_VUP;
        ST_M_VUP:  state_nxt = ST_A_V;
        ST_A_V:    state_nxt = ST_A_KEEP;
        ST_A_KEEP: state_nxt = ST_M_CHH;
        ST_M_CHH:  state_nxt = ST_M_CHV;
        ST_M_CHV:  state_nxt = ST_M_N1;
        ST_M_N1:   state_nxt = ST_A_CVH;
        ST_A_CVH:  state_nxt = ST_M_N2;
        ST_M_N2:   state_nxt = ST_A_CVV;
        ST_A_CVV:  state_nxt = ST_OUT;
        ST_OUT:    state_nxt = ST_IDLE;
        default:   state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_started_r <= 1'b0;
      out_valid_r  <= 1'b0;
      time_step_r  <= RST_TIME_STEP;
      noise_pp_r   <= RST_NOISE_PP;
      noise_pv_r   <= RST_NOISE_PV;
      noise_vv_r   <= RST_NOISE_VV;
      meas_noise_r <= RST_MEAS_NOISE;
      height_r     <= 32'sd0;
      velocity_r   <= 32'sd0;
      cov_hh_r     <= ONE_Q48;
      cov_hv_r     <= 64'sd0;
      cov_vh_r     <= 64'sd0;
      cov_vv_r     <= ONE_Q48;
    end else begin
      state_r <= state_nxt;

      if (mul_start || div_start) begin
        op_started_r <= 1'b1;
      end else if (mul_done || div_done) begin
        op_started_r <= 1'b0;
      end

      // A new result loaded in the same cycle keeps the valid high.
      if (out_valid_r && out_tready && !(state_r == ST_OUT && step_done)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TIME_STEP:  time_step_r  <= cfg_data[31:0];
          CFG_NOISE_PP:   noise_pp_r   <= cfg_data[62:0];
          CFG_NOISE_PV:   noise_pv_r   <= cfg_data[62:0];
          CFG_NOISE_VV:   noise_vv_r   <= cfg_data[62:0];
          CFG_MEAS_NOISE: meas_noise_r <= cfg_data[62:0];
          default: ;
        endcase
      end

      if (step_done) begin
        case (state_r)
          ST_IDLE:   meas_r     <= in_tdata;
          ST_M_VDT:  tmp_r      <= mul_res;
          ST_A_PS1:  ps1_r      <= alu_w32;
          ST_M_VVDT: t_r        <= mul_res;
          ST_A_P12A: p12_r      <= alu_sat;
          ST_A_P12B: p12_r      <= alu_sat;
          ST_A_P21A: p21_r      <= alu_sat;
          ST_A_S:    tmp_r      <= alu_sat;
          ST_M_SDT:  tmp_r      <= mul_res;
          ST_A_P11A: p11_r      <= alu_sat;
          ST_A_P11B: p11_r      <= alu_sat;
          ST_A_P21B: p21_r      <= alu_sat;
          ST_A_P22:  p22_r      <= alu_sat;
          ST_A_INN:  inn_r      <= alu_sat;
          ST_A_IC:   ic_r       <= alu_sat;
          ST_D_K1:   k1_r       <= ic_pos ? div_res : 64'sd0;
          ST_D_K2:   k2_r       <= ic_pos ? div_res : 64'sd0;
          ST_M_HUP:  tmp_r      <= mul_res;
          ST_A_H:    height_r   <= alu_w32;
          ST_M_VUP:  tmp_r      <= mul_res;
          ST_A_V:    velocity_r <= alu_w32;
          ST_A_KEEP: keep_r     <= alu_sat;
          ST_M_CHH:  cov_hh_r   <= mul_res;
          ST_M_CHV:  cov_hv_r   <= mul_res;
          ST_M_N1:   tmp_r      <= mul_res;
          ST_A_CVH:  cov_vh_r   <= alu_sat;
          ST_M_N2:   tmp_r      <= mul_res;
          ST_A_CVV:  cov_vv_r   <= alu_sat;
          ST_OUT: begin
            out_valid_r <= 1'b1;
            out_h_r     <= height_r;
            out_v_r     <= velocity_r;
            out_var_r   <= cov_hh_r[63] ? 63'd0 : cov_hh_r[62:0];
          end
          default: ;
        endcase
      end
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_var_r, out_v_r, out_h_r};

`ifndef SYNTHESIS
  // The multiplier and the divider never run at the same time.
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  // A unit only reports done for an operation the sequencer started.
  a_done_started: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done || div_done) |-> op_started_r)
    else $error("unit done without a started operation");

  // An accepted sample leaves the idle state on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_M_VDT))
    else $error("sequencer did not start after a sample");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the height and velocity Kalman filter.
`timescale 1ns / 1ps

module tb_top;
  import khvf_pkg::*;

  // The clock and all block inputs. Every input holds a known value from time zero.
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;    // [31:0] measured_height
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;        // [31:0] height, [63:32] velocity, [126:64] variance
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  kalman_height_velocity_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous fixed limit on the whole run. A correct run needs about 10 ms of
  // simulated time, even with every gap and stall at its longest.
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // One estimate as the block reports it.
  typedef struct packed {
    logic [31:0] height;
    logic [31:0] velocity;
    logic [62:0] variance;
  } estimate_t;

  estimate_t pending_estimates[$];

  int errors = 0;
  int samples_sent = 0;
  int estimates_seen = 0;
  int writes_done = 0;

  // When quiet is set, neither side idles or stalls.
  logic quiet = 1'b0;

  // The filter's own copy of its registers.
  logic [31:0] step_reg;
  logic [62:0] noise_pp_reg, noise_pv_reg, noise_vv_reg, noise_r_reg;

  // The filter's own copy of its state, all in 64-bit signed fixed point.
  q48_t est_h, est_v, p_hh, p_hv, p_vh, p_vv;

  function automatic logic [63:0] magnitude(input q48_t a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // Clamp an exact sum to plus or minus (2^63 - 1).
  function automatic q48_t add_sat(input q48_t a, input q48_t b);
    logic signed [64:0] sa, sb, s;
    sa = a;
    sb = b;
    s = sa + sb;
    if (s > SMAX65) return SMAX;
    else if (s < SMIN65) return -SMAX;
    else return s[63:0];
  endfunction

  function automatic q48_t clamp_word(input logic signed [64:0] x);
    if (x > 65'sd2147483647) return 64'sd2147483647;
    else if (x < -65'sd2147483648) return -64'sd2147483648;
    else return x[63:0];
  endfunction

  // Product of two fixed point values shifted right by sh, rounded half away
  // from zero on the magnitude, and saturated.
  function automatic q48_t scaled_product(input q48_t a, input q48_t b, input int sh);
    logic [127:0] p;
    logic neg;
    neg = a[63] ^ b[63];
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p > {65'd0, MASK63}) p = {65'd0, MASK63};
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  // Gain as (num << 48) / den on magnitudes, truncated and saturated.
  function automatic q48_t gain_quotient(input q48_t num, input q48_t den);
    logic [127:0] q;
    q = {16'd0, magnitude(num), 48'd0} / {64'd0, den};
    if (q > {65'd0, MASK63}) q = {65'd0, MASK63};
    return num[63] ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  // Advance the filter by one height sample and return the estimate it yields.
  function automatic estimate_t filter_update(input logic [31:0] sample);
    logic signed [31:0] sample_s;
    q48_t w;
    q48_t meas, dt, npp, npv, nvv, nr;
    q48_t ps1, ps2, t, p11, p12, p21, p22, inn, ic, k1, k2, keep;
    estimate_t e;
    sample_s = sample;
    meas = sample_s;
    dt = {32'd0, step_reg};
    npp = {1'b0, noise_pp_reg};
    npv = {1'b0, noise_pv_reg};
    nvv = {1'b0, noise_vv_reg};
    nr = {1'b0, noise_r_reg};

    // Predict: height moves by velocity times the step, velocity holds.
    // The state sums wrap in 64 bits before the 32-bit clamp.
    w = est_h;
    w = w + scaled_product(est_v, dt, 32);
    ps1 = clamp_word(w);
    ps2 = est_v;

    // Covariance propagation in the block's own order of operations.
    t = scaled_product(p_vv, dt, 32);
    p12 = add_sat(add_sat(p_hv, t), npv);
    p21 = add_sat(p_vh, t);
    p11 = add_sat(add_sat(p_hh, scaled_product(add_sat(p_hv, p21), dt, 32)), npp);
    p21 = add_sat(p21, npv);
    p22 = add_sat(p_vv, nvv);

    inn = meas - ps1;
    ic = add_sat(p11, nr);
    // A nonpositive innovation variance zeroes both gains.
    if (ic > 0) begin
      k1 = gain_quotient(p11, ic);
      k2 = gain_quotient(p21, ic);
    end else begin
      k1 = 0;
      k2 = 0;
    end

    w = ps1;
    w = w + scaled_product(k1, inn, 48);
    est_h = clamp_word(w);
    w = ps2;
    w = w + scaled_product(k2, inn, 48);
    est_v = clamp_word(w);

    keep = add_sat(ONE_Q48, -k1);
    p_hh = scaled_product(p11, keep, 48);
    p_hv = scaled_product(p12, keep, 48);
    p_vh = add_sat(p21, -scaled_product(p11, k2, 48));
    p_vv = add_sat(p22, -scaled_product(p12, k2, 48));

    e.height = est_h[31:0];
    e.velocity = est_v[31:0];
    // A negative height variance is reported as zero.
    e.variance = p_hh[63] ? 63'd0 : p_hh[62:0];
    return e;
  endfunction

  // Result checker: every accepted output beat is matched against the oldest
  // expected estimate.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      estimates_seen++;
      if (pending_estimates.size() == 0) begin
        errors++;
        $display("%0t: unexpected estimate %h", $time, out_tdata);
      end else begin
        estimate_t want;
        want = pending_estimates.pop_front();
        if (out_tdata[31:0] !== want.height) begin
          errors++;
          $display("%0t: height expected %h, got %h", $time, want.height, out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== want.velocity) begin
          errors++;
          $display("%0t: velocity expected %h, got %h", $time, want.velocity,
                   out_tdata[63:32]);
        end
        if (out_tdata[126:64] !== want.variance) begin
          errors++;
          $display("%0t: variance expected %h, got %h", $time, want.variance,
                   out_tdata[126:64]);
        end
      end
    end
  end

  // The result side stalls on about 22 percent of cycles, except while quiet.
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 22);
  end

  // Write one register. The valid stays high so that back-to-back writes need no
  // gap; whoever drives the next beat or waits for idle lowers it.
  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
    case (idx)
      CFG_TIME_STEP:  step_reg = value[31:0];
      CFG_NOISE_PP:   noise_pp_reg = value[62:0];
      CFG_NOISE_PV:   noise_pv_reg = value[62:0];
      CFG_NOISE_VV:   noise_vv_reg = value[62:0];
      CFG_MEAS_NOISE: noise_r_reg = value[62:0];
      default: ;  // Indexes past the last register are ignored.
    endcase
  endtask

  // Send one height sample. The expected estimate comes from the predictor,
  // unless a typed one is supplied.
  task automatic send_sample(input logic [31:0] sample, input logic typed,
                             input estimate_t typed_estimate);
    estimate_t predicted;
    cfg_valid <= 1'b0;
    if (!quiet && $urandom_range(99) < 22) begin
      // The gap runs up to about one full update so that it lands on every
      // stage of the block's work.
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 350)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    predicted = filter_update(sample);
    pending_estimates.push_back(typed ? typed_estimate : predicted);
  endtask

  // Drop all valids and wait until every expected estimate has arrived, so that
  // the block is idle and registers may be written.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [63:0] value;   // register data, or the height sample in the low bits
    logic        typed;
    estimate_t   result;
  } plan_row_t;

  localparam estimate_t NO_RESULT = '0;
  localparam estimate_t PINNED_HIGH = '{height: 32'h7FFF_FFFF, velocity: 32'd0,
                                       variance: 63'd0};
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // Directed plan. With zero step, zero noise and unit height variance from
  // reset, the first gain is exactly one, so the estimate jumps to the sample
  // and the variance collapses to zero. The next sample then sees a zero
  // innovation variance, so both gains are zero and the height holds.
  localparam int PLAN_ROWS = 26;
  localparam plan_row_t directed_plan[PLAN_ROWS] = '{
    '{ROW_WRITE,  CFG_TIME_STEP,  64'd0, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_PP,   64'd0, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_PV,   64'd0, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_VV,   64'd0, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_MEAS_NOISE, 64'd0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'h7FFF_FFFF, 1'b1, PINNED_HIGH},
    '{ROW_SAMPLE, 3'd0, 64'h8000_0000, 1'b1, PINNED_HIGH},
    // Writes past the last register must leave everything as it was.
    '{ROW_WRITE,  3'd5, ALL_ONES, 1'b0, NO_RESULT},
    '{ROW_WRITE,  3'd7, 64'd1,    1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'd0,    1'b0, NO_RESULT},
    // Every register at its top value; data above the register width is masked.
    '{ROW_WRITE,  CFG_TIME_STEP,  ALL_ONES, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_PP,   ALL_ONES, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_PV,   ALL_ONES, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_VV,   ALL_ONES, 1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_MEAS_NOISE, ALL_ONES, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'h8000_0000, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'h7FFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'h0000_0001, 1'b0, NO_RESULT},
    // Back to the power-on settings.
    '{ROW_WRITE,  CFG_TIME_STEP,  {32'd0, RST_TIME_STEP},  1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_PP,   {1'b0, RST_NOISE_PP},    1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_PV,   {1'b0, RST_NOISE_PV},    1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_NOISE_VV,   {1'b0, RST_NOISE_VV},    1'b0, NO_RESULT},
    '{ROW_WRITE,  CFG_MEAS_NOISE, {1'b0, RST_MEAS_NOISE},  1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'd0,          1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'hFFFF_FFFF,  1'b0, NO_RESULT},
    '{ROW_SAMPLE, 3'd0, 64'h0001_0000,  1'b0, NO_RESULT}
  };

  localparam int PHASES = 10;
  localparam int SAMPLES_PER_PHASE = 125;

  initial begin
    logic [31:0] track_h, track_v, sample;
    logic [63:0] value;
    int mode;

    // Power-on values of the predictor.
    step_reg = RST_TIME_STEP;
    noise_pp_reg = RST_NOISE_PP;
    noise_pv_reg = RST_NOISE_PV;
    noise_vv_reg = RST_NOISE_VV;
    noise_r_reg = RST_MEAS_NOISE;
    est_h = 0;
    est_v = 0;
    p_hh = ONE_Q48;
    p_hv = 0;
    p_vh = 0;
    p_vv = ONE_Q48;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (directed_plan[r].kind == ROW_WRITE) begin
        wait_idle();
        write_register(directed_plan[r].idx, directed_plan[r].value);
      end else begin
        send_sample(directed_plan[r].value[31:0], directed_plan[r].typed,
                    directed_plan[r].result);
      end
    end

    // Random phases. Each one picks new settings (power-on, zero, full scale,
    // fully random or a modest random value per register) and then feeds a
    // noisy climb or descent, with some full-range and near-limit samples.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (int idx = CFG_TIME_STEP; idx <= CFG_MEAS_NOISE; idx++) begin
        mode = (ph == 0) ? 0 : $urandom_range(0, 5);
        case (mode)
          1: value = 64'd0;
          2: value = ALL_ONES;
          3: value = {$urandom, $urandom};
          4: value = (idx == CFG_TIME_STEP) ? 64'($urandom_range(1, 1 << 28))
                                            : ({32'd0, $urandom} << $urandom_range(0, 31));
          default: begin
            case (idx)
              CFG_TIME_STEP:  value = {32'd0, RST_TIME_STEP};
              CFG_NOISE_PP:   value = {1'b0, RST_NOISE_PP};
              CFG_NOISE_PV:   value = {1'b0, RST_NOISE_PV};
              CFG_NOISE_VV:   value = {1'b0, RST_NOISE_VV};
              default:        value = {1'b0, RST_MEAS_NOISE};
            endcase
          end
        endcase
        write_register(3'(idx), value);
      end
      // Phases four and five run with no idling on either side.
      quiet = (ph == 4 || ph == 5);

      track_h = $urandom;
      track_h = {{8{track_h[31]}}, track_h[23:0]};
      track_v = $urandom_range(0, 8191) - 4096;
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        mode = $urandom_range(99);
        track_h = track_h + track_v;
        if (mode < 75) begin
          sample = track_h + $urandom_range(0, 4095) - 2048;
        end else if (mode < 90) begin
          sample = $urandom;
        end else begin
          sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                        : 32'h8000_0000 + $urandom_range(0, 15);
        end
        send_sample(sample, 1'b0, NO_RESULT);
      end
      quiet = 1'b0;
    end

    // Drain and allow for the block's latency before the verdict.
    wait_idle();
    repeat (400) @(posedge clk);

    $display("Sent %0d height samples and %0d register writes over %0d setting phases.",
             samples_sent, writes_done, PHASES + 1);
    $display("Checked %0d estimates, %0d mismatches.", estimates_seen, errors);
    if (errors == 0 && pending_estimates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
